// ===== src/wfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared constants, codes and types of the worst-fit partition allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

	// table geometry
	localparam int MAX_PARTITIONS = 16;
	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
	localparam int SIZE_W = 16;
	localparam int TOTAL_W = SIZE_W + 1;

	// operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLOSE = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ALLOCATED = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_ADDED     = 3'd2;
	localparam logic [2:0] ST_REJECTED  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic [SIZE_W-1:0] amount;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic [SIZE_W-1:0] best_left;
	} wfpa_tok_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic              wr_en;
		logic              mark_en;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] size;
	} wfpa_upd_t;

	// partition index as it leaves the block, masked to four bits
	function automatic logic [3:0] idx_to_port(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] wide;
		wide = {4'b0000, idx};
		return wide[3:0];
	endfunction

endpackage

// ===== src/wfpa_cell.sv =====
// ----------------------------------------------------------------------------
// wfpa_cell
// One partition entry: holds size and used mark, scores the passing search
// token against its entry and registers the token for the next cell.
// ----------------------------------------------------------------------------
module wfpa_cell import wfpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [CNT_W-1:0] count,
	input  wfpa_upd_t        upd,
	input  wfpa_tok_t        tok_in,
	output wfpa_tok_t        tok_out
);

	logic [SIZE_W-1:0] size_q;
	logic              used_q;
	wfpa_tok_t         tok_q;
	logic              live;
	logic              hit;
	logic              take;
	logic [SIZE_W-1:0] left;
	logic              sel;

	assign sel = (upd.idx == cell_idx);

	// entry storage, size is written before it is ever read
	always_ff @(posedge clk) begin
		if (upd.wr_en && sel) begin
			size_q <= upd.size;
		end
	end

	// used mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (upd.wr_en && sel) begin
			used_q <= 1'b0;
		end else if (upd.mark_en && sel) begin
			used_q <= 1'b1;
		end
	end

	// score the token against this entry, keep the larger leftover
	always_comb begin
		live = (CNT_W'(cell_idx) < count);
		left = size_q - tok_in.amount;
		hit  = tok_in.valid && live && !used_q && (size_q >= tok_in.amount);
		take = hit && (!tok_in.found || (left > tok_in.best_left));
	end

	// hand the token to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else begin
			tok_q.valid  <= tok_in.valid;
			tok_q.amount <= tok_in.amount;
			if (take) begin
				tok_q.found     <= 1'b1;
				tok_q.best_idx  <= cell_idx;
				tok_q.best_left <= left;
			end else begin
				tok_q.found     <= tok_in.found;
				tok_q.best_idx  <= tok_in.best_idx;
				tok_q.best_left <= tok_in.best_left;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== src/worst_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Fixed-partition table with add, close and worst-fit allocate operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready: s_tuser carries the operation
//   (add, close, allocate), s_tdata the amount. Every input word gives
//   exactly one result word on m_tvalid/m_tready: m_tuser the status,
//   m_tdata the partition index and the space left.
//   cfg_wr_en/cfg_wr_data set the memory size; write it only while idle.
// Operation flow:
//   add, close and invalid operations: the result is registered at the edge
//   that takes the input word and is valid the next cycle; the next word can
//   be taken in that cycle while the output is free.
//   allocate: a search token walks the row of MAX_PARTITIONS cells, one
//   cell per cycle, and the result is registered from the token that the
//   last cell holds; no new word is taken while the search runs.
//   The used mark is set in the same cycle the result is produced.
// Reset: clears the table count, the running total, all used marks and
//   sets the memory size to 65535. Partition sizes are not cleared.
// Stall: a result waiting in the output register does not block the next
//   input word; a second result waits in a holding register and no further
//   word is taken until the output register frees up.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator import wfpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,  // memory_size
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // [15:0] amount
	input  logic [1:0]  s_tuser,      // [1:0] op
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,      // [3:0] partition_index, [19:4] space_left, rest zero
	output logic [2:0]  m_tuser       // [2:0] status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        idx;
		logic [SIZE_W-1:0] left;
	} res_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  mem_size_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] total_q;
	res_t               res_q;
	logic               m_tvalid_q;
	res_t               m_res_q;

	wfpa_tok_t          tok [0:MAX_PARTITIONS];
	logic [MAX_PARTITIONS:0] tok_valid;
	wfpa_upd_t          upd;

	logic               accept;
	logic [1:0]         op;
	logic [SIZE_W-1:0]  amount;
	logic               full;
	logic [TOTAL_W:0]   sum;
	logic               too_big;
	logic               room;
	logic [SIZE_W-1:0]  remainder;
	logic               append;
	logic [SIZE_W-1:0]  append_size;
	logic               scan_done;
	res_t               res;
	logic               out_free;
	logic               out_load;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign op       = s_tuser;
	assign amount   = s_tdata;
	assign out_free = !m_tvalid_q || m_tready;
	assign scan_done = (state_q == S_SCAN) && tok[MAX_PARTITIONS].valid;

	// output register loads a new word
	assign out_load = out_free && (((state_q == S_IDLE) && accept && (op != OP_ALLOC))
		|| scan_done || (state_q == S_HOLD));

	// admission checks for add and close
	always_comb begin
		full      = (count_q == CNT_W'(MAX_PARTITIONS));
		sum       = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(amount);
		too_big   = (sum > (TOTAL_W+1)'(mem_size_q));
		room      = (total_q < TOTAL_W'(mem_size_q));
		remainder = mem_size_q - total_q[SIZE_W-1:0];
	end

	// decode of the taken word and of the finished search
	always_comb begin
		append      = 1'b0;
		append_size = amount;
		res.status  = ST_REJECTED;
		res.idx     = 4'd0;
		res.left    = '0;
		if (scan_done) begin
			if (tok[MAX_PARTITIONS].found) begin
				res.status = ST_ALLOCATED;
				res.idx    = idx_to_port(tok[MAX_PARTITIONS].best_idx);
				res.left   = tok[MAX_PARTITIONS].best_left;
			end else begin
				res.status = ST_NO_FIT;
			end
		end else begin
			case (op)
				OP_ADD: begin
					if (full) begin
						res.status = ST_FULL;
					end else if (!too_big) begin
						append = accept;
					end
				end
				OP_CLOSE: begin
					append_size = remainder;
					if (full) begin
						res.status = ST_FULL;
					end else if (room) begin
						append = accept;
					end
				end
				default: begin
					res.status = ST_REJECTED;
				end
			endcase
			if (append) begin
				res.status = ST_ADDED;
				res.idx    = idx_to_port(count_q[IDX_W-1:0]);
			end
		end
	end

	// table update broadcast: append on an accepted add or close, mark on a hit
	always_comb begin
		upd.wr_en   = append;
		upd.mark_en = scan_done && tok[MAX_PARTITIONS].found;
		upd.idx     = scan_done ? tok[MAX_PARTITIONS].best_idx : count_q[IDX_W-1:0];
		upd.size    = append_size;
	end

	// search token launched into the first cell
	always_comb begin
		tok[0].valid     = accept && (op == OP_ALLOC);
		tok[0].amount    = amount;
		tok[0].found     = 1'b0;
		tok[0].best_idx  = '0;
		tok[0].best_left = '0;
	end

	// row of partition cells
	for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
		wfpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.count    (count_q),
			.upd      (upd),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	for (genvar i = 0; i <= MAX_PARTITIONS; i++) begin : g_tv
		assign tok_valid[i] = tok[i].valid;
	end

	// memory size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= '1;
		end else if (cfg_wr_en) begin
			mem_size_q <= cfg_wr_data;
		end
	end

	// partition count and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (append) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= total_q + TOTAL_W'(append_size);
		end
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_ALLOC) begin
							state_q <= S_SCAN;
						end else if (out_free) begin
							m_res_q <= res;
						end else begin
							res_q   <= res;
							state_q <= S_HOLD;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (out_free) begin
							m_res_q <= res;
							state_q <= S_IDLE;
						end else begin
							res_q   <= res;
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						m_res_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {4'b0000, m_res_q.left, m_res_q.idx};

	// at most one search token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one search token in flight");

	// no token in the row while new words are taken
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok_valid[MAX_PARTITIONS:1] == '0))
		else $error("search token alive while idle");

	// table count never passes the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PARTITIONS))
		else $error("partition count overflow");

	// running total always fits the size field
	a_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		!total_q[TOTAL_W-1])
		else $error("running total beyond largest memory size");

	// a launched search ends in the last cell after one pass of the row
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok[0].valid |-> ##MAX_PARTITIONS tok[MAX_PARTITIONS].valid)
		else $error("search token lost in the row");

endmodule

// ===== tb/worst_fit_partition_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator_tb
// Self-checking bench for the worst-fit fixed-partition allocator: directed
// words on an empty table, worst-fit picks and ties, memory-size limits and
// close, then randomized traffic under several memory sizes and a
// table-full check. Every accepted input word is run through a local copy of
// the partition table, and each result word is compared with the oldest
// expected outcome.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wfpa_pkg::*;

	// unused operation code, answered with a reject
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_ROUNDS = 5;
	localparam int ROUND_WORDS = 250;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  index;
		logic [15:0] left;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	// local copy of the partition table
	logic [15:0] tbl_size [MAX_PARTITIONS];
	bit          tbl_used [MAX_PARTITIONS];
	int          tbl_count = 0;
	int          tbl_total = 0;
	logic [15:0] mem_limit = 16'hFFFF;

	outcome_t outcome_queue[$];
	int       mismatches = 0;
	bit       send_gaps = 1'b1;
	bit       recv_gaps = 1'b1;
	outcome_t want;

	worst_fit_partition_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait(input bit enabled);
		if (!enabled)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// apply one operation to the local table and return the expected word
	function automatic outcome_t worst_fit_outcome(input logic [1:0] op,
			input logic [15:0] amount);
		outcome_t    res;
		bit          found;
		int          best;
		int          best_left;
		int          slot_left;
		logic [15:0] grant;
		res = '{status: ST_REJECTED, index: 4'd0, left: 16'd0};
		found = 1'b0;
		best = 0;
		best_left = 0;
		grant = amount;
		case (op)
			OP_ADD, OP_CLOSE: begin
				if (op == OP_CLOSE)
					grant = 16'(int'(mem_limit) - tbl_total);
				if (tbl_count >= MAX_PARTITIONS) begin
					res.status = ST_FULL;
				end else if ((op == OP_ADD && tbl_total + int'(amount) > int'(mem_limit))
						|| (op == OP_CLOSE && tbl_total >= int'(mem_limit))) begin
					res.status = ST_REJECTED;
				end else begin
					tbl_size[tbl_count] = grant;
					tbl_used[tbl_count] = 1'b0;
					res.status = ST_ADDED;
					res.index = 4'(tbl_count);
					tbl_count++;
					tbl_total += int'(grant);
				end
			end
			OP_ALLOC: begin
				// free slot that fits and leaves the most over, lowest index on ties
				for (int i = 0; i < tbl_count; i++) begin
					if (!tbl_used[i] && tbl_size[i] >= amount) begin
						slot_left = int'(tbl_size[i]) - int'(amount);
						if (!found || slot_left > best_left) begin
							found = 1'b1;
							best = i;
							best_left = slot_left;
						end
					end
				end
				if (found) begin
					tbl_used[best] = 1'b1;
					res.status = ST_ALLOCATED;
					res.index = 4'(best);
					res.left = 16'(best_left);
				end else begin
					res.status = ST_NO_FIT;
				end
			end
			default: res.status = ST_REJECTED;
		endcase
		return res;
	endfunction

	// send one input word; valid stays high across back-to-back words
	task automatic send_word(input logic [1:0] op, input logic [15:0] amount);
		int gap;
		gap = draw_wait(send_gaps);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= amount;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		outcome_queue.push_back(worst_fit_outcome(op, amount));
	endtask

	// hold off until every expected word is back and the block has settled
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (outcome_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_memory_size(input logic [15:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mem_limit = value;
	endtask

	// invalid op and allocate on an empty table, under the reset memory size
	task automatic test_empty_table();
		send_word(OP_UNUSED, 16'hFFFF);
		send_word(OP_UNUSED, 16'h0000);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'hFFFF);
	endtask

	// zero-size add, worst-fit choice, lowest index on a tie, no fit
	task automatic test_worst_fit_pick();
		send_word(OP_ADD, 16'd0);
		send_word(OP_ADD, 16'd100);
		send_word(OP_ADD, 16'd100);
		send_word(OP_ALLOC, 16'd50);
		send_word(OP_ALLOC, 16'd0);
		send_word(OP_ALLOC, 16'd0);
		send_word(OP_ALLOC, 16'd1);
	endtask

	// memory size at zero, add too large, close with and without remainder
	task automatic test_memory_limits();
		write_memory_size(16'd0);
		send_word(OP_ADD, 16'd0);
		send_word(OP_CLOSE, 16'hFFFF);
		write_memory_size(16'd1000);
		send_word(OP_ADD, 16'hFFFF);
		send_word(OP_ADD, 16'd300);
		send_word(OP_CLOSE, 16'd0);
		send_word(OP_CLOSE, 16'd0);
		send_word(OP_ADD, 16'd0);
		send_word(OP_ALLOC, 16'd600);
		send_word(OP_ALLOC, 16'd300);
	endtask

	// mixed traffic in rounds, with the memory size and idle pattern set per round
	task automatic test_random_traffic();
		int          pick;
		logic [1:0]  op;
		logic [15:0] amount;
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			case (round)
				1: write_memory_size(16'($urandom_range(0, 65535)));
				3: write_memory_size(16'($urandom_range(tbl_total, 65535)));
				default: write_memory_size(16'hFFFF);
			endcase
			send_gaps = (round != 1) && (round != 3);
			recv_gaps = (round != 1) && (round != 2);
			for (int n = 0; n < ROUND_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				case ($urandom_range(0, 3))
					0: amount = 16'($urandom_range(0, 65535));
					1: amount = 16'($urandom_range(0, 255));
					default: amount = 16'($urandom_range(0, 2047));
				endcase
				if (pick < 30)
					op = OP_ADD;
				else if (pick < 34)
					op = OP_CLOSE;
				else if (pick < 95)
					op = OP_ALLOC;
				else
					op = OP_UNUSED;
				send_word(op, amount);
			end
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// fill every remaining slot, then add and close must report a full table
	task automatic test_table_full();
		write_memory_size(16'hFFFF);
		for (int n = 0; n <= MAX_PARTITIONS; n++)
			send_word(OP_ADD, 16'd0);
		send_word(OP_CLOSE, 16'd0);
		send_word(OP_ADD, 16'hFFFF);
		send_word(OP_ALLOC, 16'd0);
		send_word(OP_ALLOC, 16'hFFFF);
	endtask

	// result side: random stall before each word
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(recv_gaps);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// compare each result word with the oldest expected outcome
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected word: status %0d index %0d left %0d",
						m_tuser, m_tdata[3:0], m_tdata[19:4]);
			end else begin
				want = outcome_queue.pop_front();
				if (m_tuser !== want.status || m_tdata[3:0] !== want.index
						|| m_tdata[19:4] !== want.left) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("word mismatch: expected status %0d index %0d left %0d, got status %0d index %0d left %0d",
							want.status, want.index, want.left,
							m_tuser, m_tdata[3:0], m_tdata[19:4]);
				end
			end
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		for (int i = 0; i < MAX_PARTITIONS; i++) begin
			tbl_size[i] = '0;
			tbl_used[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_worst_fit_pick();
		test_memory_limits();
		test_random_traffic();
		test_table_full();
		drain_results();
		if (outcome_queue.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("worst_fit_partition_allocator: match");
		else
			$display("worst_fit_partition_allocator: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("worst_fit_partition_allocator: mismatch");
		$finish;
	end

endmodule
